[src/mh64_pkg.sv]
// ----------------------------------------------------------------------------
// mh64_pkg
// Shared types, constants and helper functions for the 64-bit MurmurHash block.
// ----------------------------------------------------------------------------
package mh64_pkg;

    localparam logic [63:0] MH_K     = 64'hC6A4A7935BD1E995;
    localparam int unsigned MH_SHIFT = 47;
    localparam logic [3:0]  FULL_CNT = 4'd8;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last_word;
        logic [63:0] message_length;
    } mh64_in_t;

    typedef struct packed {
        logic [63:0] hash_value;
        logic        length_error;
    } mh64_out_t;

    function automatic logic [63:0] shiftmix(input logic [63:0] v);
        return v ^ (v >> MH_SHIFT);
    endfunction

    // Keeps the lowest cnt bytes of a word.
    function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            m[i*8 +: 8] = (4'(i) < cnt) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

[src/murmur_hash_64.sv]
// ----------------------------------------------------------------------------
// murmur_hash_64
// MurmurHash64A over a message streamed as 64-bit little-endian words.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_ready is low until that word is fully mixed
// and, for a last word, until its hash is loaded into the output register.
// Every 64-bit product by the hash constant runs through one shared 32x32
// multiplier in three passes. A full word needs two products and the state
// multiply, a short word one, the first word of a message one more for the
// length, and the last word one more for finalization. The hash comes out
// through a one-entry output register, so the next word is taken while a hash
// waits to be read.
module murmur_hash_64
    import mh64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  mh64_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output mh64_out_t   out_data
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DISP  = 8'b0000_0010,
        S_INIT  = 8'b0000_0100,
        S_WMUL1 = 8'b0000_1000,
        S_WMUL2 = 8'b0001_0000,
        S_HMUL  = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] seed_reg;
    logic [63:0] h_reg, h_next;
    logic [63:0] rem_reg, rem_next;
    logic        err_reg, err_next;
    logic        open_reg, open_next;
    logic [63:0] word_reg, word_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [63:0] op_reg, op_next;
    logic        start_reg, start_next;
    logic        out_valid_reg, out_valid_next;
    mh64_out_t   out_reg, out_next;

    logic        mul_busy;
    logic        mul_done;
    logic [63:0] mul_result;

    logic        accept;
    logic [63:0] rem_cur;
    logic [3:0]  cnt_c;
    logic        out_free;

    mh64_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .operand (op_reg),
        .busy    (mul_busy),
        .done    (mul_done),
        .result  (mul_result)
    );

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign rem_cur  = open_reg ? rem_reg : in_data.message_length;
    assign cnt_c    = (in_data.byte_count > FULL_CNT) ? FULL_CNT : in_data.byte_count;

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        rem_next       = rem_reg;
        err_next       = err_reg;
        open_next      = open_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        op_next        = op_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    err_next = (open_reg && err_reg)
                             || (in_data.byte_count > FULL_CNT)
                             || (cnt_c != FULL_CNT && !in_data.last_word);
                    if ({60'd0, cnt_c} > rem_cur)
                    begin
                        err_next = 1'b1;
                        rem_next = '0;
                    end
                    else
                    begin
                        rem_next = rem_cur - {60'd0, cnt_c};
                    end
                    word_next = in_data.data_word & byte_mask(cnt_c);
                    cnt_next  = cnt_c;
                    last_next = in_data.last_word;
                    open_next = 1'b1;
                    if (!open_reg)
                    begin
                        op_next    = in_data.message_length;
                        start_next = 1'b1;
                        state_next = S_INIT;
                    end
                    else
                    begin
                        state_next = S_DISP;
                    end
                end
            end
            S_INIT:
            begin
                if (mul_done)
                begin
                    h_next     = seed_reg ^ mul_result;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                start_next = 1'b1;
                if (cnt_reg == FULL_CNT)
                begin
                    op_next    = word_reg;
                    state_next = S_WMUL1;
                end
                else if (cnt_reg != 4'd0)
                begin
                    op_next    = h_reg ^ word_reg;
                    state_next = S_HMUL;
                end
                else if (last_reg)
                begin
                    op_next    = shiftmix(h_reg);
                    state_next = S_FIN;
                end
                else
                begin
                    start_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_WMUL1:
            begin
                if (mul_done)
                begin
                    op_next    = shiftmix(mul_result);
                    start_next = 1'b1;
                    state_next = S_WMUL2;
                end
            end
            S_WMUL2:
            begin
                if (mul_done)
                begin
                    op_next    = h_reg ^ mul_result;
                    start_next = 1'b1;
                    state_next = S_HMUL;
                end
            end
            S_HMUL:
            begin
                if (mul_done)
                begin
                    h_next = mul_result;
                    if (last_reg)
                    begin
                        op_next    = shiftmix(mul_result);
                        start_next = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                if (mul_done)
                begin
                    h_next     = mul_result;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next.hash_value   = shiftmix(h_reg);
                    out_next.length_error = err_reg || (rem_reg != 64'd0);
                    out_valid_next        = 1'b1;
                    open_next             = 1'b0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= '0;
            h_reg         <= '0;
            rem_reg       <= '0;
            err_reg       <= 1'b0;
            open_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            rem_reg       <= rem_next;
            err_reg       <= err_next;
            open_reg      <= open_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                seed_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        op_reg   <= op_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Multiplier is never restarted mid-product.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !mul_busy)
        else $error("multiplier started while busy");

    // Words are only taken with the multiplier quiet.
    a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!mul_busy && !start_reg))
        else $error("ready while multiply in flight");

    // A new message always loads its length product first.
    a_first_init: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !open_reg) |=> (state_reg == S_INIT && start_reg))
        else $error("first word did not start length multiply");

    // A hash is only produced from the finishing state.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside finish");

    // Products only complete while a multiply state waits on them.
    a_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_INIT || state_reg == S_WMUL1
                      || state_reg == S_WMUL2 || state_reg == S_HMUL
                      || state_reg == S_FIN))
        else $error("multiply result with no consumer");

endmodule

[src/mh64_mul.sv]
// ----------------------------------------------------------------------------
// mh64_mul
// Multiply by the hash constant modulo 2^64, three passes of one 32x32 unit.
// ----------------------------------------------------------------------------
module mh64_mul
    import mh64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        busy,
    output logic        done,
    output logic [63:0] result
);

    localparam logic [1:0] STEP_LL = 2'd0;  // a_lo * k_lo
    localparam logic [1:0] STEP_LH = 2'd1;  // a_lo * k_hi, upper half only
    localparam logic [1:0] STEP_HL = 2'd2;  // a_hi * k_lo, upper half only

    logic [31:0] a_lo_reg;
    logic [31:0] a_hi_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    always_comb
    begin
        mul_a = (step_reg == STEP_HL) ? a_hi_reg : a_lo_reg;
        mul_b = (step_reg == STEP_LH) ? MH_K[63:32] : MH_K[31:0];
        prod  = mul_a * mul_b;
        if (step_reg == STEP_LL)
        begin
            acc_next = prod;
        end
        else
        begin
            acc_next = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= STEP_LL;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            busy_reg <= (step_reg != STEP_HL);
            done_reg <= (step_reg == STEP_HL);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_lo_reg <= operand[31:0];
            a_hi_reg <= operand[63:32];
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for murmur_hash_64. Directed words cover empty, short, full and
// multi-word messages and every framing error. Random messages follow, mostly
// well formed with some noise. Stalls on both handshakes and seed changes
// between phases add variation. A scoreboard predicts each hash and its
// error flag and checks every result word in order.
// ----------------------------------------------------------------------------
class hash_scoreboard;

    logic [63:0] seed;
    logic [63:0] acc;
    logic        open;
    logic [63:0] left;
    logic        err;
    mh64_pkg::mh64_out_t hashes_due[$];
    int unsigned errors;

    function new();
        seed   = '0;
        acc    = '0;
        open   = 1'b0;
        left   = '0;
        err    = 1'b0;
        errors = 0;
    endfunction

    function logic [63:0] fold(input logic [63:0] v);
        return v ^ (v >> 47);
    endfunction

    function int unsigned pending();
        return hashes_due.size();
    endfunction

    function void note_word(input mh64_pkg::mh64_in_t w);
        logic [63:0] v;
        logic [63:0] keep;
        logic [3:0]  n;
        mh64_pkg::mh64_out_t r;
        if (!open)
        begin
            acc  = seed ^ (w.message_length * mh64_pkg::MH_K);
            left = w.message_length;
            err  = 1'b0;
            open = 1'b1;
        end
        n = w.byte_count;
        if (n > 4'd8)
        begin
            n   = 4'd8;
            err = 1'b1;
        end
        if (n < 4'd8 && !w.last_word)
            err = 1'b1;
        if (64'(n) > left)
        begin
            err  = 1'b1;
            left = '0;
        end
        else
            left = left - 64'(n);
        if (n == 4'd8)
        begin
            v   = w.data_word * mh64_pkg::MH_K;
            v   = fold(v) * mh64_pkg::MH_K;
            acc = acc ^ v;
            acc = acc * mh64_pkg::MH_K;
        end
        else if (n != 4'd0)
        begin
            keep = (64'd1 << (8 * n)) - 64'd1;
            acc  = acc ^ (w.data_word & keep);
            acc  = acc * mh64_pkg::MH_K;
        end
        if (w.last_word)
        begin
            if (left != 0)
                err = 1'b1;
            v = fold(acc) * mh64_pkg::MH_K;
            r.hash_value   = fold(v);
            r.length_error = err;
            hashes_due.push_back(r);
            open = 1'b0;
        end
    endfunction

    function void check_hash(input mh64_pkg::mh64_out_t got);
        mh64_pkg::mh64_out_t want;
        if (hashes_due.size() == 0)
        begin
            $error("unexpected result word: hash_value %h length_error %b",
                   got.hash_value, got.length_error);
            errors++;
            return;
        end
        want = hashes_due.pop_front();
        if (got.hash_value !== want.hash_value)
        begin
            $error("hash_value: expected %h, actual %h", want.hash_value, got.hash_value);
            errors++;
        end
        if (got.length_error !== want.length_error)
        begin
            $error("length_error: expected %b, actual %b",
                   want.length_error, got.length_error);
            errors++;
        end
    endfunction

endclass

module tb;

    import mh64_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTLE      = 64;
    localparam int unsigned PHASE_WORDS = 280;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    mh64_in_t    in_data;
    logic        out_valid;
    logic        out_ready;
    mh64_out_t   out_data;

    hash_scoreboard sb;

    int unsigned cycles;
    int unsigned words_sent;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned hold_request;

    murmur_hash_64 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_word(input logic [63:0] d, input logic [3:0] n, input logic l,
                             input logic [63:0] len);
        mh64_in_t w;
        w.data_word      = d;
        w.byte_count     = n;
        w.last_word      = l;
        w.message_length = len;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        int unsigned left;
        int unsigned n;
        bit          first;
        left  = len;
        first = 1'b1;
        if (len == 0)
            send_word(rand64(), 4'd0, 1'b1, 64'd0);
        while (left > 0)
        begin
            n    = (left >= 8) ? 8 : left;
            left = left - n;
            send_word(rand64(), n[3:0], left == 0, first ? 64'(len) : rand64());
            first = 1'b0;
        end
    endtask

    // Random counts, a last flag that is sometimes missing, declared length off.
    task automatic send_noise();
        int unsigned nw;
        logic [63:0] mlen;
        nw   = $urandom_range(1, 4);
        mlen = ($urandom_range(1) != 0) ? 64'($urandom_range(0, 40)) : rand64();
        for (int unsigned i = 0; i < nw; i++)
        begin
            send_word(rand64(), 4'($urandom_range(0, 15)),
                      (i == nw - 1) && ($urandom_range(3) != 0),
                      (i == 0) ? mlen : rand64());
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.seed = v;
    endtask

    task automatic random_phase(input int unsigned idle, input int unsigned stall);
        int unsigned target;
        idle_pct  = idle;
        stall_pct = stall;
        target    = words_sent + PHASE_WORDS;
        while (words_sent < target)
        begin
            if ($urandom_range(99) < 78)
            begin
                if ($urandom_range(99) < 85)
                    send_message($urandom_range(0, 24));
                else
                    send_message($urandom_range(25, 120));
            end
            else
                send_noise();
        end
        drain();
    endtask

    // Result side: stalls at random, or for a requested long hold.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_hash(out_data);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("murmur_hash_64: mismatch");
        $finish;
    end

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        words_sent   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset seed
        send_word(rand64(), 4'd0, 1'b1, 64'd0);
        send_word({64{1'b1}}, 4'd8, 1'b1, 64'd8);
        send_word(64'hFFFF_FFFF_FFFF_FFA5, 4'd1, 1'b1, 64'd1);
        send_word({64{1'b1}}, 4'd7, 1'b1, 64'd7);
        send_word(rand64(), 4'd8, 1'b0, 64'd15);
        send_word(rand64(), 4'd7, 1'b1, rand64());
        send_word(64'd0, 4'd8, 1'b0, 64'd16);
        send_word(rand64(), 4'd8, 1'b1, 64'd0);
        send_word(rand64(), 4'd15, 1'b1, 64'd8);
        send_word(rand64(), 4'd9, 1'b1, 64'd8);
        send_word(rand64(), 4'd3, 1'b0, 64'd11);
        send_word(rand64(), 4'd8, 1'b1, 64'd0);
        send_word(rand64(), 4'd8, 1'b1, 64'd4);
        send_word(rand64(), 4'd8, 1'b1, 64'd20);
        send_word(rand64(), 4'd8, 1'b1, {64{1'b1}});
        send_word(64'd0, 4'd8, 1'b1, 64'd8);
        send_word(rand64(), 4'd0, 1'b0, 64'd0);
        send_word(rand64(), 4'd0, 1'b1, 64'd0);
        drain();

        write_seed({64{1'b1}});
        random_phase(0, 0);
        write_seed(rand64());
        random_phase(46, 0);
        write_seed(64'd0);
        random_phase(0, 46);
        write_seed(rand64());
        random_phase(29, 29);

        // output held off while single-word messages keep coming
        write_seed(64'h8000_0000_0000_0001);
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 500;
        repeat (24) send_message(8);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("murmur_hash_64: match");
        else
            $display("murmur_hash_64: mismatch");
        $finish;
    end

endmodule

[sim.f]
src/mh64_pkg.sv
src/mh64_mul.sv
src/murmur_hash_64.sv
tb/sv/tb.sv
